/* design/cie_pkg.sv */
// shared types and constants of the custom isa execute unit
`default_nettype none

package cie_pkg;

   localparam int PC_W        = 12;
   localparam int RAM_AW      = 16;
   localparam int RAM_DEPTH   = 1 << RAM_AW;
   localparam int LEN_W       = 13;
   localparam int OPC_W       = 5;
   localparam int REG_IN_W    = 4;
   localparam int IMM_W       = 16;
   localparam int OUT_DATA_W  = 32;

   localparam int RSP_FIFO_DEPTH = 4;
   localparam int RSP_FIFO_PTR_W = 2;
   localparam int RSP_FIFO_CNT_W = 3;

   localparam int CSR_AW     = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_AW-3:0] CSR_IDX_PROGRAM_LENGTH = '0;

   typedef enum logic [OPC_W-1:0] {
      OP_LD   = 5'd0,
      OP_ST   = 5'd1,
      OP_ADD  = 5'd2,
      OP_SUB  = 5'd3,
      OP_ADDI = 5'd4,
      OP_AND  = 5'd5,
      OP_OR   = 5'd6,
      OP_SHL  = 5'd7,
      OP_SHR  = 5'd8,
      OP_BEQ  = 5'd9,
      OP_BLE  = 5'd10,
      OP_BLT  = 5'd11,
      OP_JSUB = 5'd12,
      OP_RET  = 5'd13,
      OP_PUSH = 5'd14,
      OP_POP  = 5'd15
   } op_type;

   typedef struct packed {
      logic [PC_W-1:0]       next_pc;
      logic                  reg_write;
      logic [REG_IN_W-1:0]   write_reg;
      logic [OUT_DATA_W-1:0] write_value;
      logic                  mem_write;
      logic [RAM_AW-1:0]     mem_addr;
      logic [OUT_DATA_W-1:0] mem_data;
      logic                  branch_taken;
      logic                  illegal;
      logic                  halted;
   } rsp_type;

endpackage

`default_nettype wire

/* design/cie_regfile.sv */
// register file: two synchronous banks with registered reads and per-entry valid bits
`default_nettype none

module cie_regfile #(
   parameter int REG_COUNT  = 16,
   parameter int DATA_WIDTH = 32,
   parameter int IDX_W      = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  rd_en,
   input  wire logic [IDX_W-1:0]      rd_addr_a,
   input  wire logic [IDX_W-1:0]      rd_addr_b,
   input  wire logic [IDX_W-1:0]      rd_addr_c,
   output logic      [DATA_WIDTH-1:0] rd_data_a,
   output logic      [DATA_WIDTH-1:0] rd_data_b,
   output logic      [DATA_WIDTH-1:0] rd_data_c,
   input  wire logic                  wr_en,
   input  wire logic [IDX_W-1:0]      wr_addr,
   input  wire logic [DATA_WIDTH-1:0] wr_data
);

   logic [DATA_WIDTH-1:0] bank_a  [REG_COUNT];
   logic [DATA_WIDTH-1:0] bank_bc [REG_COUNT];
   logic [REG_COUNT-1:0]  valid_ff;

   logic [DATA_WIDTH-1:0] data_a_ff;
   logic [DATA_WIDTH-1:0] data_b_ff;
   logic [DATA_WIDTH-1:0] data_c_ff;
   logic                  valid_a_ff;
   logic                  valid_b_ff;
   logic                  valid_c_ff;

   // read-first banks
   always_ff @(posedge clock) begin
      if (wr_en) begin
         bank_a[wr_addr]  <= wr_data;
         bank_bc[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         data_a_ff <= bank_a[rd_addr_a];
         data_b_ff <= bank_bc[rd_addr_b];
         data_c_ff <= bank_bc[rd_addr_c];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            valid_a_ff <= valid_ff[rd_addr_a];
            valid_b_ff <= valid_ff[rd_addr_b];
            valid_c_ff <= valid_ff[rd_addr_c];
         end
      end
   end

   // never-written registers read as zero
   assign rd_data_a = valid_a_ff ? data_a_ff : '0;
   assign rd_data_b = valid_b_ff ? data_b_ff : '0;
   assign rd_data_c = valid_c_ff ? data_c_ff : '0;

endmodule

`default_nettype wire

/* design/cie_data_mem.sv */
// single-port data memory with registered read
`default_nettype none

module cie_data_mem #(
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                      clock,
   input  wire logic                      rd_en,
   input  wire logic                      wr_en,
   input  wire logic [cie_pkg::RAM_AW-1:0] addr,
   input  wire logic [DATA_WIDTH-1:0]     wr_data,
   output logic      [DATA_WIDTH-1:0]     rd_data
);

   import cie_pkg::*;

   logic [DATA_WIDTH-1:0] mem [RAM_DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end else if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* design/cie_rsp_fifo.sv */
// result queue between the execute pipeline and the response channel
`default_nettype none

module cie_rsp_fifo (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              push,
   input  wire cie_pkg::rsp_type                  push_data,
   input  wire logic                              pop,
   output logic                                   head_valid,
   output cie_pkg::rsp_type                       head_data,
   output logic      [cie_pkg::RSP_FIFO_CNT_W-1:0] count
);

   import cie_pkg::*;

   rsp_type                   entry_ff [RSP_FIFO_DEPTH];
   logic [RSP_FIFO_PTR_W-1:0] wr_ptr_ff;
   logic [RSP_FIFO_PTR_W-1:0] rd_ptr_ff;
   logic [RSP_FIFO_CNT_W-1:0] count_ff;
   logic [RSP_FIFO_CNT_W-1:0] count_in;
   logic                      do_pop;

   assign head_valid = (count_ff != '0);
   assign do_pop     = pop && head_valid;

   always_comb begin
      count_in = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + RSP_FIFO_CNT_W'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - RSP_FIFO_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + RSP_FIFO_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + RSP_FIFO_PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   assign head_data = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

`default_nettype wire

/* design/custom_isa_execute_unit.sv */
// top level: custom isa execute unit with register file, data memory and result queue
// a request runs through stage 1 and stage 2, then into the result queue that drives rsp_valid
// throughput: one request per cycle unless req_stall, paced by the single data memory port
// and the register file read registered ahead of execute, forwarding from the two later stages
// reset clears pc, link register, stack pointer, program length and the register file
// valid bits (registers read as zero); data memory is not cleared and needs no sweep
`default_nettype none

module custom_isa_execute_unit #(
   parameter int REG_COUNT  = 16,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,

   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic        [cie_pkg::OPC_W-1:0]   req_type,
   input  wire logic        [cie_pkg::REG_IN_W-1:0] req_reg_a,
   input  wire logic        [cie_pkg::REG_IN_W-1:0] req_reg_b,
   input  wire logic        [cie_pkg::REG_IN_W-1:0] req_reg_c,
   input  wire logic signed [cie_pkg::IMM_W-1:0]   req_imm,

   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [cie_pkg::PC_W-1:0]                rsp_next_pc,
   output logic                                    rsp_reg_write,
   output logic [cie_pkg::REG_IN_W-1:0]            rsp_write_reg,
   output logic [cie_pkg::OUT_DATA_W-1:0]          rsp_write_value,
   output logic                                    rsp_mem_write,
   output logic [cie_pkg::RAM_AW-1:0]              rsp_mem_addr,
   output logic [cie_pkg::OUT_DATA_W-1:0]          rsp_mem_data,
   output logic                                    rsp_branch_taken,
   output logic                                    rsp_illegal,
   output logic                                    rsp_halted,

   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [cie_pkg::CSR_AW-1:0]         csr_paddr,
   input  wire logic [cie_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic      [cie_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                    csr_pready
);

   import cie_pkg::*;

   localparam int IDX_W = $clog2(REG_COUNT);
   localparam int SH_W  = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;
   localparam logic [DATA_WIDTH-1:0] SHIFT_LIMIT = DATA_WIDTH'(DATA_WIDTH);

   function automatic logic [IDX_W-1:0] reg_index(input logic [REG_IN_W-1:0] raw);
      logic [7:0] v;
      v = {4'b0, raw};
      for (int i = 0; i < 8; i++) begin
         if (v >= 8'(REG_COUNT)) begin
            v = v - 8'(REG_COUNT);
         end
      end
      return v[IDX_W-1:0];
   endfunction

   function automatic logic [OUT_DATA_W-1:0] to_out(input logic [DATA_WIDTH-1:0] val);
      logic [DATA_WIDTH+OUT_DATA_W-1:0] wide;
      wide = {{OUT_DATA_W{1'b0}}, val};
      return wide[OUT_DATA_W-1:0];
   endfunction

   // configuration
   logic [LEN_W-1:0] program_length_ff;
   logic             csr_hit;

   assign csr_hit    = (csr_paddr[CSR_AW-1:2] == CSR_IDX_PROGRAM_LENGTH);
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? CSR_DATA_W'(program_length_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         program_length_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_hit) begin
         program_length_ff <= csr_pwdata[LEN_W-1:0];
      end
   end

   // request acceptance against queue space
   logic                      req_acc;
   logic [RSP_FIFO_CNT_W-1:0] fifo_count;
   logic [RSP_FIFO_CNT_W-1:0] committed;
   logic                      s1_v_ff;
   logic                      s2_v_ff;

   assign committed = fifo_count + RSP_FIFO_CNT_W'(s1_v_ff) + RSP_FIFO_CNT_W'(s2_v_ff);
   assign req_stall = (committed >= RSP_FIFO_CNT_W'(RSP_FIFO_DEPTH));
   assign req_acc   = req_valid && !req_stall;

   // stage 1 registers
   op_type           s1_op_ff;
   logic [IDX_W-1:0] s1_ia_ff;
   logic [IDX_W-1:0] s1_ib_ff;
   logic [IDX_W-1:0] s1_ic_ff;
   logic [IMM_W-1:0] s1_imm_ff;

   logic [IDX_W-1:0] in_ia;
   logic [IDX_W-1:0] in_ib;
   logic [IDX_W-1:0] in_ic;

   assign in_ia = reg_index(req_reg_a);
   assign in_ib = reg_index(req_reg_b);
   assign in_ic = reg_index(req_reg_c);

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_op_ff  <= op_type'(req_type);
         s1_ia_ff  <= in_ia;
         s1_ib_ff  <= in_ib;
         s1_ic_ff  <= in_ic;
         s1_imm_ff <= req_imm;
      end
   end

   // register file
   logic [DATA_WIDTH-1:0] rf_a;
   logic [DATA_WIDTH-1:0] rf_b;
   logic [DATA_WIDTH-1:0] rf_c;
   logic                  rf_we;
   logic [DATA_WIDTH-1:0] s2_value;

   // stage 2 registers
   logic                  s2_rw_ff;
   logic                  s2_load_ff;
   logic [IDX_W-1:0]      s2_ia_ff;
   logic [DATA_WIDTH-1:0] s2_alu_ff;
   rsp_type               s2_rsp_ff;

   // last register file write, for the request that read during it
   logic                  wb_v_ff;
   logic [IDX_W-1:0]      wb_ia_ff;
   logic [DATA_WIDTH-1:0] wb_val_ff;

   assign rf_we = s2_v_ff && s2_rw_ff;

   cie_regfile #(
      .REG_COUNT  (REG_COUNT),
      .DATA_WIDTH (DATA_WIDTH),
      .IDX_W      (IDX_W)
   ) u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_acc),
      .rd_addr_a (in_ia),
      .rd_addr_b (in_ib),
      .rd_addr_c (in_ic),
      .rd_data_a (rf_a),
      .rd_data_b (rf_b),
      .rd_data_c (rf_c),
      .wr_en     (rf_we),
      .wr_addr   (s2_ia_ff),
      .wr_data   (s2_value)
   );

   // operand forwarding
   function automatic logic [DATA_WIDTH-1:0] fwd(
      input logic [IDX_W-1:0]      idx,
      input logic [DATA_WIDTH-1:0] rf_val,
      input logic                  s2_hit_en,
      input logic [IDX_W-1:0]      s2_idx,
      input logic [DATA_WIDTH-1:0] s2_val,
      input logic                  wb_hit_en,
      input logic [IDX_W-1:0]      wb_idx,
      input logic [DATA_WIDTH-1:0] wb_val
   );
      logic [DATA_WIDTH-1:0] r;
      r = rf_val;
      if (s2_hit_en && (s2_idx == idx)) begin
         r = s2_val;
      end else if (wb_hit_en && (wb_idx == idx)) begin
         r = wb_val;
      end
      return r;
   endfunction

   logic [DATA_WIDTH-1:0] va;
   logic [DATA_WIDTH-1:0] vb;
   logic [DATA_WIDTH-1:0] vc;

   assign va = fwd(s1_ia_ff, rf_a, rf_we, s2_ia_ff, s2_value, wb_v_ff, wb_ia_ff, wb_val_ff);
   assign vb = fwd(s1_ib_ff, rf_b, rf_we, s2_ia_ff, s2_value, wb_v_ff, wb_ia_ff, wb_val_ff);
   assign vc = fwd(s1_ic_ff, rf_c, rf_we, s2_ia_ff, s2_value, wb_v_ff, wb_ia_ff, wb_val_ff);

   // architectural pointers
   logic [PC_W-1:0]   pc_ff;
   logic [PC_W-1:0]   link_ff;
   logic [RAM_AW-1:0] sp_ff;
   logic [PC_W-1:0]   pc_in;
   logic [PC_W-1:0]   link_in;
   logic [RAM_AW-1:0] sp_in;

   // stage 1 execute
   logic [DATA_WIDTH+IMM_W-1:0]  imm_wide;
   logic [DATA_WIDTH-1:0]        immx;
   logic [DATA_WIDTH-1:0]        addr_sum;
   logic [DATA_WIDTH+RAM_AW-1:0] addr_wide;
   logic [RAM_AW-1:0]            addr_ls;
   logic [RAM_AW-1:0]            sp_dec;

   logic                  ex_rw;
   logic                  ex_mw;
   logic                  ex_access;
   logic                  ex_load;
   logic                  ex_taken;
   logic                  ex_bad;
   logic [DATA_WIDTH-1:0] ex_alu;
   logic [RAM_AW-1:0]     ex_maddr;
   logic [PC_W-1:0]       ex_npc;
   rsp_type               ex_rsp;

   assign imm_wide  = {{DATA_WIDTH{s1_imm_ff[IMM_W-1]}}, s1_imm_ff};
   assign immx      = imm_wide[DATA_WIDTH-1:0];
   assign addr_sum  = vb + immx;
   assign addr_wide = {{RAM_AW{1'b0}}, addr_sum};
   assign addr_ls   = addr_wide[RAM_AW-1:0];
   assign sp_dec    = sp_ff - RAM_AW'(1);

   always_comb begin
      ex_rw     = 1'b0;
      ex_mw     = 1'b0;
      ex_access = 1'b0;
      ex_load   = 1'b0;
      ex_taken  = 1'b0;
      ex_bad    = 1'b0;
      ex_alu    = '0;
      ex_maddr  = '0;
      link_in   = link_ff;
      sp_in     = sp_ff;
      ex_npc    = pc_ff + PC_W'(1);
      unique case (s1_op_ff) inside
         OP_LD: begin
            ex_rw     = 1'b1;
            ex_load   = 1'b1;
            ex_access = 1'b1;
            ex_maddr  = addr_ls;
         end
         OP_ST: begin
            ex_mw     = 1'b1;
            ex_access = 1'b1;
            ex_maddr  = addr_ls;
         end
         OP_ADD, OP_SUB, OP_ADDI, OP_AND, OP_OR, OP_SHL, OP_SHR: begin
            ex_rw = 1'b1;
            case (s1_op_ff)
               OP_ADD:  ex_alu = vb + vc;
               OP_SUB:  ex_alu = vb - vc;
               OP_ADDI: ex_alu = addr_sum;
               OP_AND:  ex_alu = vb & vc;
               OP_OR:   ex_alu = vb | vc;
               OP_SHL:  ex_alu = (vc >= SHIFT_LIMIT) ? '0 : (vb << vc[SH_W-1:0]);
               default: ex_alu = (vc >= SHIFT_LIMIT) ? '0 : (vb >> vc[SH_W-1:0]);
            endcase
         end
         OP_BEQ: ex_taken = (va == vb);
         OP_BLE: ex_taken = (va <= vb);
         OP_BLT: ex_taken = (va < vb);
         OP_JSUB: begin
            ex_taken = 1'b1;
            link_in  = pc_ff;
         end
         OP_RET: begin
            ex_taken = 1'b1;
         end
         OP_PUSH: begin
            ex_mw     = 1'b1;
            ex_access = 1'b1;
            ex_maddr  = sp_dec;
            sp_in     = sp_dec;
         end
         OP_POP: begin
            ex_rw     = 1'b1;
            ex_load   = 1'b1;
            ex_access = 1'b1;
            ex_maddr  = sp_ff;
            sp_in     = sp_ff + RAM_AW'(1);
         end
         default: begin
            ex_bad = 1'b1;
         end
      endcase
      if (s1_op_ff == OP_RET) begin
         ex_npc = link_ff + PC_W'(1);
      end else if (ex_taken) begin
         ex_npc = pc_ff + s1_imm_ff[PC_W-1:0];
      end
      pc_in = ex_npc;
   end

   always_comb begin
      ex_rsp              = '0;
      ex_rsp.next_pc      = ex_npc;
      ex_rsp.reg_write    = ex_rw;
      ex_rsp.mem_write    = ex_mw;
      ex_rsp.mem_addr     = ex_access ? ex_maddr : '0;
      ex_rsp.mem_data     = ex_mw ? to_out(va) : '0;
      ex_rsp.branch_taken = ex_taken;
      ex_rsp.illegal      = ex_bad;
      ex_rsp.halted       = ({1'b0, ex_npc} >= program_length_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= '0;
         link_ff <= '0;
         sp_ff   <= '0;
      end else if (s1_v_ff) begin
         pc_ff   <= pc_in;
         link_ff <= link_in;
         sp_ff   <= sp_in;
      end
   end

   // data memory, accessed at the end of stage 1
   logic [DATA_WIDTH-1:0] mem_rd;

   cie_data_mem #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_data_mem (
      .clock   (clock),
      .rd_en   (s1_v_ff && ex_load),
      .wr_en   (s1_v_ff && ex_mw),
      .addr    (ex_maddr),
      .wr_data (va),
      .rd_data (mem_rd)
   );

   always_ff @(posedge clock) begin
      s2_rw_ff   <= ex_rw;
      s2_load_ff <= ex_load;
      s2_ia_ff   <= s1_ia_ff;
      s2_alu_ff  <= ex_alu;
      s2_rsp_ff  <= ex_rsp;
   end

   // stage 2 writeback
   logic [IDX_W+REG_IN_W-1:0] ia_wide;
   rsp_type                   wb_rsp;

   assign s2_value = s2_load_ff ? mem_rd : s2_alu_ff;
   assign ia_wide  = {{REG_IN_W{1'b0}}, s2_ia_ff};

   always_comb begin
      wb_rsp             = s2_rsp_ff;
      wb_rsp.write_reg   = s2_rw_ff ? ia_wide[REG_IN_W-1:0] : '0;
      wb_rsp.write_value = s2_rw_ff ? to_out(s2_value) : '0;
   end

   always_ff @(posedge clock) begin
      wb_ia_ff  <= s2_ia_ff;
      wb_val_ff <= s2_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         wb_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= req_acc;
         s2_v_ff <= s1_v_ff;
         wb_v_ff <= rf_we;
      end
   end

   // result queue
   rsp_type head;

   cie_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (s2_v_ff),
      .push_data  (wb_rsp),
      .pop        (!rsp_stall),
      .head_valid (rsp_valid),
      .head_data  (head),
      .count      (fifo_count)
   );

   assign rsp_next_pc      = head.next_pc;
   assign rsp_reg_write    = head.reg_write;
   assign rsp_write_reg    = head.write_reg;
   assign rsp_write_value  = head.write_value;
   assign rsp_mem_write    = head.mem_write;
   assign rsp_mem_addr     = head.mem_addr;
   assign rsp_mem_data     = head.mem_data;
   assign rsp_branch_taken = head.branch_taken;
   assign rsp_illegal      = head.illegal;
   assign rsp_halted       = head.halted;

endmodule

`default_nettype wire
